@@ sv/mme_pkg.sv @@
// Package: shared types for the modular exponentiation block.
`timescale 1ns / 1ps
package mme_pkg;

   // Status of the shared modular multiply unit
   typedef struct packed {
      logic busy;   // a multiply is in progress
      logic done;   // one-cycle pulse: product is valid
   } mme_status_type;

endpackage

@@ sv/mme_mulmod.sv @@
// Module: bit-serial modular multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module mme_mulmod import mme_pkg::*; #(
   parameter int WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDTH-1:0]     x,
   input  logic [WIDTH-1:0]     y,
   input  logic [WIDTH-1:0]     m,
   output mme_status_type       status,
   output logic [WIDTH-1:0]     product
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam logic [CW-1:0] LAST_BIT = CW'(WIDTH - 1);

   logic [WIDTH-1:0] x_ff, y_ff, m_ff, acc_ff;
   logic [WIDTH-1:0] y_in, acc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;

   logic [WIDTH-1:0] addend;
   logic [WIDTH+1:0] sum, diff_one, diff_two, m_one, m_two;

   // acc < m and x < m, so 2*acc + x < 3m: one of three candidates fits
   always_comb begin
      addend   = y_ff[WIDTH-1] ? x_ff : '0;
      sum      = {1'b0, acc_ff, 1'b0} + {2'b00, addend};
      m_one    = {2'b00, m_ff};
      m_two    = {1'b0, m_ff, 1'b0};
      diff_one = sum - m_one;
      diff_two = sum - m_two;
   end

   always_comb begin
      y_in    = y_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         y_in    = y;
         acc_in  = '0;
         cnt_in  = LAST_BIT;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sum >= m_two) begin
            acc_in = diff_two[WIDTH-1:0];
         end else if (sum >= m_one) begin
            acc_in = diff_one[WIDTH-1:0];
         end else begin
            acc_in = sum[WIDTH-1:0];
         end
         y_in   = {y_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands x and m hold between loads; y and acc follow the next-state logic
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         x_ff <= x;
         m_ff <= m;
      end
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

@@ sv/modular_exponentiation_64.sv @@
// Top level: modular exponentiation by right-to-left square-and-multiply.
`timescale 1ns / 1ps
//
//  channel   ports                                          direction  handshake
//  --------  ---------------------------------------------  ---------  ------------------
//  request   req_base_value, req_exponent, req_modulus      in         start & !busy
//  response  rsp_power_result                               out        rsp_valid strobe
//
// Sequence: a modulus of 0 or 1 never raises busy; its strobe is in the cycle
// right after the accepting edge. Otherwise the block runs a series of modular
// multiplies on the shared bit-serial unit, W = OPERAND_WIDTH, each a load and
// then W shift steps: the base reduction is one multiply, every exponent bit
// costs one square plus one sequencer step, and every set bit one more
// multiply.
// Reset clears the sequencer and the multiplier control; no clearing pass.
// busy is high from the accepting edge until the result strobe; rsp_valid is
// high for one cycle per result and the receiver cannot stall it.
module modular_exponentiation_64 import mme_pkg::*; #(
   parameter int OPERAND_WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OPERAND_WIDTH-1:0] req_base_value,
   input  logic [OPERAND_WIDTH-1:0] req_exponent,
   input  logic [OPERAND_WIDTH-1:0] req_modulus,
   output logic                     rsp_valid,
   output logic [OPERAND_WIDTH-1:0] rsp_power_result
);

   localparam int W  = OPERAND_WIDTH;
   localparam int BW = $clog2(W + 1);
   localparam logic [BW-1:0] BIT_END = BW'(W);

   // sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_NEXT   = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_SQR    = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [W-1:0]  res_ff, res_in, b_ff, b_in, e_ff, e_in, m_ff, m_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  rsp_result_ff, rsp_result_in;

   // shared multiplier port
   logic           mm_start;
   logic [W-1:0]   mm_x, mm_y, mm_product;
   mme_status_type mm_status;

   logic accept;
   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      bit_in        = bit_ff;
      res_in        = res_ff;
      b_in          = b_ff;
      e_in          = e_ff;
      m_in          = m_ff;
      rsp_valid_in  = 1'b0;
      rsp_result_in = rsp_result_ff;
      mm_start      = 1'b0;
      mm_x          = res_ff;
      mm_y          = b_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               e_in   = req_exponent;
               m_in   = req_modulus;
               bit_in = '0;
               res_in = W'(1);
               if (req_modulus <= W'(1)) begin
                  // modulus of zero or one: answer zero at once
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = '0;
               end else begin
                  // reduce the base: Horner over its bits with multiplicand 1
                  mm_start = 1'b1;
                  mm_x     = W'(1);
                  mm_y     = req_base_value;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_status.done) begin
               b_in     = mm_product;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (bit_ff == BIT_END) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
               state_in      = ST_IDLE;
            end else if (e_ff[0]) begin
               mm_start = 1'b1;
               state_in = ST_MUL;
            end else begin
               mm_start = 1'b1;
               mm_x     = b_ff;
               state_in = ST_SQR;
            end
         end
         ST_MUL: begin
            if (mm_status.done) begin
               // fold in the set bit, then square the base
               res_in   = mm_product;
               mm_start = 1'b1;
               mm_x     = b_ff;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            if (mm_status.done) begin
               // advance to the next exponent bit
               b_in     = mm_product;
               e_in     = {1'b0, e_ff[W-1:1]};
               bit_in   = bit_ff + BW'(1);
               state_in = ST_NEXT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_ff       <= bit_in;
      end
   end

   // datapath words: no reset needed
   always_ff @(posedge clock) begin
      res_ff        <= res_in;
      b_ff          <= b_in;
      e_ff          <= e_in;
      m_ff          <= m_in;
      rsp_result_ff <= rsp_result_in;
   end

   // single shared modular multiplier; modulus taken from the request while idle, else from the stored copy
   mme_mulmod #(
      .WIDTH (W)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .x       (mm_x),
      .y       (mm_y),
      .m       ((state_ff == ST_IDLE) ? req_modulus : m_ff),
      .status  (mm_status),
      .product (mm_product)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;

   // a strobe that stays high past its cycle needs a fresh word accepted while it was high
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> (!rsp_valid_ff || $past(accept)))
      else $error("result strobe held longer than one cycle");

   // every result is reduced by the modulus of its request
   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_result_ff < m_ff) || ((m_ff <= W'(1)) && (rsp_result_ff == '0))))
      else $error("result not below modulus");

   // the multiplier is only started while idle
   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      mm_start |-> !mm_status.busy)
      else $error("multiplier started while busy");

   // a product only arrives while the sequencer waits for one
   a_done_waiting: assert property (@(posedge clock) disable iff (reset)
      mm_status.done |->
         ((state_ff == ST_REDUCE) || (state_ff == ST_MUL) || (state_ff == ST_SQR)))
      else $error("product arrived in a state not waiting for it");

   // an accepted word makes the block busy or answers at once
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid_ff))
      else $error("accepted word dropped");

endmodule

@@ dv/tb.sv @@
// Testbench top: checks modular_exponentiation_64 against a 128-bit product predictor.
`timescale 1ns / 1ps
module tb;
   import mme_pkg::*;

   localparam int W          = 64;
   // A word with every exponent bit set takes longest to answer;
   // allow several times its run before calling the run hung.
   localparam int IDLE_LIMIT = 40000;
   localparam int TAIL_CYCLES = 20;

   typedef struct {
      logic [W-1:0] base_value;
      logic [W-1:0] exponent;
      logic [W-1:0] modulus;
      logic [W-1:0] power_result;
   } power_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   logic [W-1:0] req_base_value = '0;
   logic [W-1:0] req_exponent   = '0;
   logic [W-1:0] req_modulus    = '0;
   logic         rsp_valid;
   logic [W-1:0] rsp_power_result;

   // Words accepted by the block whose result has not come back yet, oldest first.
   power_word_type pending_powers[$];
   int             error_count = 0;
   int             idle_cycles = 0;
   int             max_gap     = 0;   // upper bound of the sender's random pause

   modular_exponentiation_64 #(.OPERAND_WIDTH(W)) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_base_value   (req_base_value),
      .req_exponent     (req_exponent),
      .req_modulus      (req_modulus),
      .rsp_valid        (rsp_valid),
      .rsp_power_result (rsp_power_result)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: exact (x * y) mod m through the full double-width product.
   // ---------------------------------------------------------------------
   function automatic logic [W-1:0] product_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                                input logic [W-1:0] m);
      logic [2*W-1:0] product;
      product = {{W{1'b0}}, x} * {{W{1'b0}}, y};
      return W'(product % {{W{1'b0}}, m});
   endfunction

   // Right-to-left square-and-multiply over every exponent bit.
   function automatic logic [W-1:0] expected_power(input logic [W-1:0] b, input logic [W-1:0] e,
                                                   input logic [W-1:0] m);
      logic [W-1:0] acc;
      logic [W-1:0] square;
      if (m == '0) return '0;
      acc    = (m == W'(1)) ? '0 : W'(1);
      square = b % m;
      for (int i = 0; i < W; i++) begin
         if (e[i]) acc = product_mod(acc, square, m);
         square = product_mod(square, square, m);
      end
      return acc;
   endfunction

   function automatic logic [W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // ---------------------------------------------------------------------
   // Sender. Start is left high after acceptance so that a zero gap sends the
   // next word back to back; it is lowered only when a pause begins or a drain
   // starts, which keeps start to one nonblocking assignment per edge.
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [W-1:0] b, input logic [W-1:0] e,
                            input logic [W-1:0] m);
      int             gap;
      power_word_type word;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_base_value <= b;
      req_exponent   <= e;
      req_modulus    <= m;
      // Hold the word until an edge sees busy low: that edge accepts it.
      do @(posedge clock); while (busy);
      word.base_value   = b;
      word.exponent     = e;
      word.modulus      = m;
      word.power_result = expected_power(b, e, m);
      pending_powers.push_back(word);
   endtask

   // Drop start and wait until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_powers.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Result checker: the strobe lasts one cycle, so sample it at the edge
   // that ends that cycle and compare with the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      power_word_type word;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_powers.size() == 0) begin
            $display("%0t unexpected result: expected none actual %h", $time,
                     rsp_power_result);
            error_count++;
         end else begin
            word = pending_powers.pop_front();
            if (rsp_power_result !== word.power_result) begin
               $display("%0t power_result mismatch (b=%h e=%h m=%h): expected %h actual %h",
                        $time, word.base_value, word.exponent, word.modulus,
                        word.power_result, rsp_power_result);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with neither an accepted word nor a result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------

   // Zero modulus and modulus of one both answer zero, whatever the rest.
   task automatic test_degenerate_moduli();
      send_word(64'd5, 64'd3, 64'd0);
      send_word('1, '1, 64'd0);
      send_word(64'd0, 64'd0, 64'd0);
      send_word('1, '1, 64'd1);
      send_word(64'd0, 64'd0, 64'd1);
      send_word(64'd9, 64'd0, 64'd1);
   endtask

   // Zero exponent gives one; zero base with a nonzero exponent gives zero.
   task automatic test_zero_exponent_and_base();
      send_word(64'd7, 64'd0, 64'd13);
      send_word(64'd0, 64'd0, '1);
      send_word('1, 64'd0, 64'd2);
      send_word(64'd0, 64'd5, 64'd97);
      send_word(64'd0, '1, '1);
   endtask

   // Field extremes, base above the modulus, and a few known powers.
   task automatic test_operand_extremes();
      send_word('1, '1, '1);
      send_word('1 - 64'd1, '1, '1);
      send_word('1, 64'd1, '1 - 64'd1);
      send_word(64'd1000, 64'd3, 64'd7);
      send_word(64'd2, 64'd10, 64'd1000);
      send_word(64'd2, '1, 64'hFFFF_FFFF_FFFF_FFC5);
      send_word(64'd3, '1, 64'h8000_0000_0000_0000);
      send_word('1, '1, 64'd2);
      send_word(64'd1, '1, '1);
      send_word(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_0000_0001);
   endtask

   // ---------------------------------------------------------------------
   // Random tests
   // ---------------------------------------------------------------------
   task automatic send_random_word();
      logic [W-1:0] b;
      logic [W-1:0] e;
      logic [W-1:0] m;
      b = rand_word();
      e = rand_word();
      m = rand_word();
      case ($urandom_range(0, 9))
         6: m = W'($urandom_range(0, 3));                 // degenerate or tiny moduli
         7: e = e >> $urandom_range(0, W - 1);            // short exponent
         8: begin                                         // large modulus, base near it
            m[W-1] = 1'b1;
            b      = m - W'($urandom_range(0, 2));
         end
         9: begin                                         // trivial base or exponent
            if ($urandom_range(0, 1)) b = W'($urandom_range(0, 1));
            else e = $urandom_range(0, 1) ? '1 : W'($urandom_range(0, 2));
         end
         default: ;
      endcase
      send_word(b, e, m);
   endtask

   task automatic test_random_back_to_back(input int count);
      max_gap = 0;
      repeat (count) send_random_word();
   endtask

   task automatic test_random_with_gaps(input int count);
      max_gap = 17;
      repeat (count) send_random_word();
   endtask

   // Pause the sender after each word until the block has answered.
   task automatic test_drain_between_words(input int count);
      max_gap = 17;
      repeat (count) begin
         send_random_word();
         drain_results();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence: reset once, directed words, random words, then drain and judge.
   // ---------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      max_gap = 3;
      test_degenerate_moduli();
      test_zero_exponent_and_base();
      test_operand_extremes();
      test_random_back_to_back(20);
      test_random_with_gaps(50);
      test_drain_between_words(10);
      // Drain every result, then watch a little longer for a stray strobe.
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_powers.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
